// ----- rtl/core/mx_pkg.sv -----
// Shared widths and a modular addition helper for the modular exponentiation block.
package mx_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    word_t gap;
    gap = m - b;
    add_mod = (a >= gap) ? (a - gap) : (a + b);
  endfunction

endpackage

// ----- rtl/core/mx_modred.sv -----
// Bit-serial restoring reduction of an operand modulo the modulus.
module mx_modred (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mx_pkg::word_t    num_in,
  input  mx_pkg::word_t    m,
  output logic             done,
  output mx_pkg::word_t    rem
);

  mx_pkg::word_t num;
  mx_pkg::cnt_t  cnt;
  logic          busy;
  logic [mx_pkg::WIDTH:0] shifted;
  logic [mx_pkg::WIDTH:0] diff;

  always_comb begin
    shifted = {rem, num[mx_pkg::WIDTH-1]};
    diff    = shifted - {1'b0, m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mx_pkg::CNT_W'(mx_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= num_in;
      rem <= '0;
    end else if (busy) begin
      num <= {num[mx_pkg::WIDTH-2:0], 1'b0};
      if (shifted >= {1'b0, m}) begin
        rem <= diff[mx_pkg::WIDTH-1:0];
      end else begin
        rem <= shifted[mx_pkg::WIDTH-1:0];
      end
    end
  end

endmodule

// ----- rtl/core/mx_modmul.sv -----
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module mx_modmul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mx_pkg::word_t    a_in,
  input  mx_pkg::word_t    b_in,
  input  mx_pkg::word_t    m,
  output logic             done,
  output mx_pkg::word_t    acc
);

  mx_pkg::word_t a;
  mx_pkg::word_t b;
  mx_pkg::cnt_t  cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == mx_pkg::CNT_W'(mx_pkg::WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= a_in;
      b   <= b_in;
      acc <= '0;
    end else if (busy) begin
      if (b[0]) begin
        acc <= mx_pkg::add_mod(acc, a, m);
      end
      a <= mx_pkg::add_mod(a, a, m);
      b <= {1'b0, b[mx_pkg::WIDTH-1:1]};
    end
  end

endmodule

// ----- rtl/core/modular_exponentiation.sv -----
// Top level: right-to-left binary modular exponentiation with bit-serial arithmetic.
// A zero modulus goes straight to the done state; a base that reduces to zero ends after the
// reduction; else the reduction is followed by one square-and-multiply round per exponent bit
// up to the highest set bit. One item at a time; the serial multipliers set the rate.
// A new item may be taken while the previous result waits at the output register.
// Reset: synchronous, active high; clears the controller and the output valid.
module modular_exponentiation (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mx_pkg::word_t    base,
  input  mx_pkg::word_t    exponent,
  input  mx_pkg::word_t    modulus,
  output logic             out_valid,
  input  logic             out_ready,
  output mx_pkg::word_t    result,
  output logic             error
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_LOOP   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state;
  mx_pkg::word_t e;
  mx_pkg::word_t m;
  mx_pkg::word_t b;
  mx_pkg::word_t r;
  logic          err;

  logic          in_xfer;
  logic          red_start;
  logic          red_done;
  mx_pkg::word_t red_rem;
  logic          mul_start;
  logic          mr_done;
  mx_pkg::word_t mr_acc;
  logic          sq_done;
  mx_pkg::word_t sq_acc;

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign red_start = in_xfer && (modulus != '0);
  assign mul_start = (state == S_LOOP) && (e != '0);

  mx_modred u_red (
    .clk    (clk),
    .rst    (rst),
    .start  (red_start),
    .num_in (base),
    .m      (m),
    .done   (red_done),
    .rem    (red_rem)
  );

  mx_modmul u_mr (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (r),
    .b_in  (b),
    .m     (m),
    .done  (mr_done),
    .acc   (mr_acc)
  );

  mx_modmul u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (b),
    .b_in  (b),
    .m     (m),
    .done  (sq_done),
    .acc   (sq_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (modulus == '0) ? S_DONE : S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (red_done) begin
            state <= (red_rem == '0) ? S_DONE : S_LOOP;
          end
        end
        S_LOOP: begin
          state <= (e == '0) ? S_DONE : S_MUL;
        end
        S_MUL: begin
          if (sq_done) begin
            state <= S_LOOP;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          m   <= modulus;
          e   <= exponent;
          err <= (modulus == '0);
          r   <= (modulus == '0) ? '0 : mx_pkg::word_t'(1);
        end
      end
      S_REDUCE: begin
        if (red_done) begin
          b <= red_rem;
          if (red_rem == '0) begin
            r <= '0;
          end
        end
      end
      S_MUL: begin
        if (sq_done) begin
          if (e[0]) begin
            r <= mr_acc;
          end
          b <= sq_acc;
          e <= {1'b0, e[mx_pkg::WIDTH-1:1]};
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          result <= r;
          error  <= err;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst) mr_done == sq_done)
    else $error("multipliers out of step");
  a_mul_in_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_MUL)
    else $error("multiplier finished outside the multiply state");
  a_red_in_state: assert property (@(posedge clk) disable iff (rst)
    red_done |-> state == S_REDUCE)
    else $error("reduction finished outside the reduce state");
  a_zero_mod: assert property (@(posedge clk) disable iff (rst)
    in_xfer && modulus == '0 |=> state == S_DONE && err && r == '0)
    else $error("zero modulus not flagged");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the modular exponentiation block: directed table, then random.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = mx_pkg::WIDTH;
  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_OFF_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 1200;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam logic FLAG_OK = 1'b0;
  localparam logic FLAG_ERR = 1'b1;

  typedef mx_pkg::word_t word_t;

  typedef struct packed {
    word_t base;
    word_t exponent;
    word_t modulus;
    bit    typed;
    word_t want_value;
    logic  want_error;
  } operands_t;

  typedef struct packed {
    word_t value;
    logic  error;
  } power_t;

  localparam operands_t DIRECTED [20] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, TYPED, 32'h0000_0000, FLAG_ERR},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, TYPED, 32'h0000_0000, FLAG_ERR},
    '{32'h0000_0005, 32'h0000_0000, 32'h0000_0001, TYPED, 32'h0000_0000, FLAG_OK},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0007, TYPED, 32'h0000_0000, FLAG_OK},
    '{32'h0000_000E, 32'h0000_0003, 32'h0000_0007, TYPED, 32'h0000_0000, FLAG_OK},
    '{32'h0000_0003, 32'h0000_0000, 32'h0000_0007, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'h0000_0002, 32'h0000_000A, 32'h0000_03E8, TYPED, 32'h0000_0018, FLAG_OK},
    '{32'h0000_0003, 32'h0000_0004, 32'h0000_0064, TYPED, 32'h0000_0051, FLAG_OK},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, TYPED, 32'h0000_0000, FLAG_OK},
    '{32'hFFFF_FFFE, 32'h0000_0002, 32'hFFFF_FFFF, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, 32'hFFFF_FFFE, FLAG_OK},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF, TYPED, 32'h8000_0000, FLAG_OK},
    '{32'h0000_0002, 32'h0000_0020, 32'hFFFF_FFFF, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, PREDICTED, 32'h0, FLAG_OK},
    '{32'h0000_3039, 32'h8000_0000, 32'h000F_4243, PREDICTED, 32'h0, FLAG_OK},
    '{32'hDEAD_BEEF, 32'h0000_0001, 32'h8000_0000, TYPED, 32'h5EAD_BEEF, FLAG_OK},
    '{32'h0000_0007, 32'h0000_0002, 32'h0000_0002, TYPED, 32'h0000_0001, FLAG_OK},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, TYPED, 32'h0000_0000, FLAG_OK}
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t base = '0;
  word_t exponent = '0;
  word_t modulus = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t result;
  logic  error;

  operands_t pending_operands [$];
  power_t    awaited_powers [$];
  operands_t on_offer;
  int        total_items = 0;
  int        items_accepted = 0;
  int        powers_seen = 0;
  int        mismatches = 0;
  logic      hold_off = 1'b0;

  modular_exponentiation dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base      (base),
    .exponent  (exponent),
    .modulus   (modulus),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .error     (error)
  );

  always #5 clk = ~clk;

  function automatic power_t power_mod(word_t b, word_t e, word_t m);
    logic [2*W-1:0] m_wide;
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    power_t p;
    m_wide = {{W{1'b0}}, m};
    p.value = '0;
    p.error = FLAG_OK;
    if (m == '0) begin
      p.error = FLAG_ERR;
      return p;
    end
    sq = {{W{1'b0}}, b} % m_wide;
    if (sq == '0)
      return p;
    acc = (2*W)'(1);
    for (int i = 0; i < W; i++) begin
      if (e[i])
        acc = (acc * sq) % m_wide;
      sq = (sq * sq) % m_wide;
    end
    p.value = acc[W-1:0];
    return p;
  endfunction

  function automatic operands_t random_operands();
    operands_t op;
    int pick;
    op.typed = PREDICTED;
    op.want_value = '0;
    op.want_error = FLAG_OK;
    pick = $urandom_range(99);
    if (pick < 5)
      op.modulus = '0;
    else if (pick < 10)
      op.modulus = 32'd1;
    else if (pick < 22)
      op.modulus = $urandom_range(64, 2);
    else if (pick < 27)
      op.modulus = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000;
    else
      op.modulus = $urandom;
    pick = $urandom_range(99);
    if (pick < 8)
      op.base = op.modulus * $urandom_range(3);
    else if (pick < 13)
      op.base = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    else
      op.base = $urandom;
    if ($urandom_range(99) < 30)
      op.exponent = $urandom;
    else
      op.exponent = $urandom >> $urandom_range(32);
    return op;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_operands
    bit     sender_quiet;
    power_t expected;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (on_offer.typed) begin
          expected.value = on_offer.want_value;
          expected.error = on_offer.want_error;
        end else begin
          expected = power_mod(on_offer.base, on_offer.exponent, on_offer.modulus);
        end
        awaited_powers = {awaited_powers, expected};
        items_accepted++;
      end
      sender_quiet = (items_accepted >= 150 && items_accepted < 200);
      if (!in_valid || in_ready) begin
        if (pending_operands.size() != 0 && (sender_quiet || $urandom_range(99) >= 16)) begin
          on_offer = pending_operands.pop_front();
          in_valid <= 1'b1;
          base     <= on_offer.base;
          exponent <= on_offer.exponent;
          modulus  <= on_offer.modulus;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= !hold_off &&
                   ((powers_seen >= 150 && powers_seen < 200) || $urandom_range(99) >= 16);
  end

  always @(posedge clk) begin : check_powers
    power_t want;
    if (!rst && out_valid && out_ready) begin
      powers_seen++;
      if (awaited_powers.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer result=%h error=%b", result, error));
      end else begin
        want = awaited_powers.pop_front();
        if (result !== want.value)
          flag_mismatch($sformatf("transfer %0d result %h, want %h",
                                  powers_seen, result, want.value));
        if (error !== want.error)
          flag_mismatch($sformatf("transfer %0d error %b, want %b",
                                  powers_seen, error, want.error));
      end
    end
  end

  initial begin
    while (powers_seen < 40)
      @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    foreach (DIRECTED[i])
      pending_operands = {pending_operands, DIRECTED[i]};
    repeat (RANDOM_ITEMS) pending_operands = {pending_operands, random_operands()};
    total_items = pending_operands.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (items_accepted < total_items || awaited_powers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- modular_exponentiation.f -----
rtl/core/mx_pkg.sv
rtl/core/mx_modred.sv
rtl/core/mx_modmul.sv
rtl/core/modular_exponentiation.sv
verif/tb.sv
